// ===== rtl/eft_pkg.sv =====
// ----------------------------------------------------------------------------
// eft_pkg
// Shared types and constants of the eased fade tween: field widths, register
// indexes, mode codes, controller states and datapath operations.
// ----------------------------------------------------------------------------
`default_nettype none

package eft_pkg;

  // Field widths
  localparam int LevelW = 16;
  localparam int RateW  = 16;
  localparam int DtW    = 16;
  localparam int ModeW  = 2;
  localparam int PhaseW = 18;
  localparam int AddrW  = 2;
  localparam int OutW   = 24;

  // Phase constants, Q2.16
  localparam logic [PhaseW-1:0] PhaseOne  = 18'd65536;
  localparam logic [PhaseW-1:0] PhaseMax  = 18'h3FFFF;
  localparam logic [16:0]       EaseOne   = 17'd65536;
  localparam logic [16:0]       EaseHalf  = 17'd32768;

  // Configuration register indexes
  localparam logic [AddrW-1:0] REG_START_LEVEL = 2'd0;
  localparam logic [AddrW-1:0] REG_END_LEVEL   = 2'd1;
  localparam logic [AddrW-1:0] REG_RATE        = 2'd2;
  localparam logic [AddrW-1:0] REG_START_MODE  = 2'd3;

  // Mode codes
  localparam logic [ModeW-1:0] MODE_BRIGHT    = 2'd0;
  localparam logic [ModeW-1:0] MODE_DARK      = 2'd1;
  localparam logic [ModeW-1:0] MODE_GO_DARK   = 2'd2;
  localparam logic [ModeW-1:0] MODE_GO_BRIGHT = 2'd3;

  // Request kinds carried in tuser
  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_START = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_MUL_INC,
    ST_MUL_SQ,
    ST_MUL_OFF,
    ST_UPDATE,
    ST_EMIT
  } eft_state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_START,
    OP_HOLD,
    OP_FINISH,
    OP_MUL_INC,
    OP_MUL_SQ,
    OP_MUL_OFF,
    OP_UPDATE
  } eft_op_t;

  // Controller to datapath
  typedef struct packed {
    logic    capture;
    eft_op_t op;
    logic    emit;
  } eft_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic start;
    logic active;
    logic phase_le_one;
  } eft_stat_t;

endpackage

`default_nettype wire

// ===== rtl/eased_fade_tween.sv =====
// ----------------------------------------------------------------------------
// eased_fade_tween
// Eased fade engine: quadratic ease-in-out between two levels, stepped by
// timed tick requests, with a start request and dark/bright end modes.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  s_*      | in        | s_tvalid / s_tready | tuser: cmd; tdata: delta_time
//  m_*      | out       | m_tvalid / m_tready | tdata: level, went_dark, running, mode
//  cfg_*    | in        | cfg_we              | cfg_addr index, cfg_wdata value
//
//  A running tick passes through dispatch, three shared-multiplier passes,
//  update and emit before its result is registered; start requests, idle ticks
//  and ending ticks go from dispatch straight to emit.
//  Reset is synchronous; no item is accepted while one is in progress.
//  A new request is taken while the previous result still waits in the
//  output register; emit stalls until that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module eased_fade_tween import eft_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [AddrW-1:0]  cfg_addr,
  input  logic [LevelW-1:0] cfg_wdata,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [DtW-1:0]    s_tdata,   // [15:0] delta_time
  input  logic              s_tuser,   // [0] cmd
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OutW-1:0]   m_tdata    // [15:0] level, [16] went_dark,
                                       // [17] running, [19:18] mode, [23:20] zero
);

  eft_cmd_t  cmd;
  eft_stat_t stat;

  // Sequencer
  eft_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Arithmetic and state
  eft_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd       (cmd),
    .stat      (stat),
    .m_tdata   (m_tdata)
  );

endmodule

`default_nettype wire

// ===== rtl/eft_ctrl.sv =====
// ----------------------------------------------------------------------------
// eft_ctrl
// Sequencer of the eased fade tween: takes one request at a time, steps the
// datapath through its multiplies and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module eft_ctrl import eft_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  output logic      m_tvalid,
  input  logic      m_tready,
  input  eft_stat_t stat,
  output eft_cmd_t  cmd
);

  eft_state_t state;
  eft_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output valid: set on emit, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign s_tready = (state == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '{capture: 1'b0, op: OP_NONE, emit: 1'b0};
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        priority if (stat.start) begin
          cmd.op     = OP_START;
          state_next = ST_EMIT;
        end else if (!stat.active) begin
          cmd.op     = OP_HOLD;
          state_next = ST_EMIT;
        end else if (!stat.phase_le_one) begin
          cmd.op     = OP_FINISH;
          state_next = ST_EMIT;
        end else begin
          state_next = ST_MUL_INC;
        end
      end
      ST_MUL_INC: begin
        cmd.op     = OP_MUL_INC;
        state_next = ST_MUL_SQ;
      end
      ST_MUL_SQ: begin
        cmd.op     = OP_MUL_SQ;
        state_next = ST_MUL_OFF;
      end
      ST_MUL_OFF: begin
        cmd.op     = OP_MUL_OFF;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.op     = OP_UPDATE;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // An accepted request is classified in the following cycle
  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_DISPATCH))
    else $error("accepted request not dispatched");

  // Never overwrite a result that is still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!m_tvalid || m_tready))
    else $error("result emitted over a pending one");

  // Multiply steps run back to back
  a_mul_chain: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL_INC) |=> (state == ST_MUL_SQ))
    else $error("multiply sequence broken");

endmodule

`default_nettype wire

// ===== rtl/eft_dpath.sv =====
// ----------------------------------------------------------------------------
// eft_dpath
// Datapath of the eased fade tween: configuration registers, animation state,
// one shared 17x17 multiplier and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module eft_dpath import eft_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [AddrW-1:0]  cfg_addr,
  input  logic [LevelW-1:0] cfg_wdata,
  input  logic [DtW-1:0]    s_tdata,
  input  logic              s_tuser,
  input  eft_cmd_t          cmd,
  output eft_stat_t         stat,
  output logic [OutW-1:0]   m_tdata
);

  // Configuration
  logic [LevelW-1:0] start_level;
  logic [LevelW-1:0] end_level;
  logic [RateW-1:0]  rate;
  logic [ModeW-1:0]  start_mode;

  // Captured request
  logic [DtW-1:0] dt_r;
  logic           cmd_r;

  // Animation state
  logic [PhaseW-1:0] phase;
  logic              active;
  logic [ModeW-1:0]  mode_reg;
  logic [LevelW-1:0] level_reg;
  logic              dark_flag;

  // Intermediate results
  logic [23:0] inc_r;
  logic [16:0] ease_r;
  logic [17:0] off_r;
  logic [OutW-1:0] out_data;

  // Combinational terms
  logic [16:0] t;
  logic        t_low;
  logic [16:0] x;
  logic [16:0] span;
  logic [16:0] mag;
  logic [16:0] mul_a;
  logic [16:0] mul_b;
  logic [33:0] prod;
  logic [16:0] sq_shr;
  logic [16:0] ease_calc;
  logic [17:0] off_calc;
  logic signed [18:0] s19;
  logic signed [18:0] o19;
  logic signed [18:0] r19;
  logic [LevelW-1:0]  level_calc;
  logic [24:0] phase_sum;
  logic [PhaseW-1:0]  phase_sat;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      start_level <= '0;
      end_level   <= '0;
      rate        <= 16'd256;
      start_mode  <= MODE_BRIGHT;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_START_LEVEL: start_level <= cfg_wdata;
        REG_END_LEVEL:   end_level   <= cfg_wdata;
        REG_RATE:        rate        <= cfg_wdata;
        REG_START_MODE:  start_mode  <= cfg_wdata[ModeW-1:0];
        default: ;
      endcase
    end
  end

  // Ease operand: fold the upper half onto the lower one
  assign t     = phase[16:0];
  assign t_low = (t <= EaseHalf);
  assign x     = t_low ? t : (EaseOne - t);

  // Distance between levels, 17 bit signed, and its magnitude
  assign span = {end_level[LevelW-1], end_level} - {start_level[LevelW-1], start_level};
  assign mag  = span[16] ? (17'd0 - span) : span;

  // Shared multiplier operand select
  always_comb begin
    unique case (cmd.op)
      OP_MUL_INC: begin
        mul_a = {1'b0, dt_r};
        mul_b = {1'b0, rate};
      end
      OP_MUL_SQ: begin
        mul_a = x;
        mul_b = x;
      end
      OP_MUL_OFF: begin
        mul_a = mag;
        mul_b = ease_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod      = {17'd0, mul_a} * {17'd0, mul_b};
  assign sq_shr    = prod[31:15];
  assign ease_calc = t_low ? sq_shr : (EaseOne - sq_shr);
  assign off_calc  = 18'((prod + 34'd32768) >> 16);

  // New level: start plus signed offset, clamped to 16 bit
  assign s19 = {{3{start_level[LevelW-1]}}, start_level};
  assign o19 = {1'b0, off_r};
  assign r19 = span[16] ? (s19 - o19) : (s19 + o19);
  always_comb begin
    priority if (r19 > 19'sd32767) begin
      level_calc = 16'h7FFF;
    end else if (r19 < -19'sd32768) begin
      level_calc = 16'h8000;
    end else begin
      level_calc = r19[LevelW-1:0];
    end
  end

  // Saturating phase advance
  assign phase_sum = {7'd0, phase} + {1'b0, inc_r};
  assign phase_sat = (phase_sum > {7'd0, PhaseMax}) ? PhaseMax : phase_sum[PhaseW-1:0];

  // Capture request and intermediate products
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      dt_r  <= s_tdata;
      cmd_r <= s_tuser;
    end
    if (cmd.op == OP_MUL_INC) begin
      inc_r <= prod[31:8];
    end
    if (cmd.op == OP_MUL_SQ) begin
      ease_r <= ease_calc;
    end
    if (cmd.op == OP_MUL_OFF) begin
      off_r <= off_calc;
    end
    if (cmd.emit) begin
      out_data <= {4'd0, mode_reg, active, dark_flag, level_reg};
    end
  end

  // Animation state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= '0;
      active    <= 1'b0;
      mode_reg  <= MODE_BRIGHT;
      level_reg <= '0;
      dark_flag <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_START: begin
          phase     <= '0;
          active    <= 1'b1;
          mode_reg  <= start_mode;
          dark_flag <= 1'b0;
        end
        OP_HOLD: begin
          dark_flag <= 1'b0;
        end
        OP_FINISH: begin
          active    <= 1'b0;
          dark_flag <= (mode_reg == MODE_GO_DARK);
          if (mode_reg == MODE_GO_DARK) begin
            mode_reg <= MODE_DARK;
          end else if (mode_reg == MODE_GO_BRIGHT) begin
            mode_reg <= MODE_BRIGHT;
          end
        end
        OP_UPDATE: begin
          level_reg <= level_calc;
          phase     <= phase_sat;
          dark_flag <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign stat    = '{start: (cmd_r == REQ_START), active: active,
                     phase_le_one: (phase <= PhaseOne)};
  assign m_tdata = out_data;

  // Phase never moves backwards on an update
  a_phase_mono: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_UPDATE) |=> (phase >= $past(phase)))
    else $error("phase decreased");

  // Finishing leaves no transition mode and no animation
  a_finish_mode: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_FINISH) |=>
      (!active && mode_reg != MODE_GO_DARK && mode_reg != MODE_GO_BRIGHT))
    else $error("finish left a transition mode");

  // The dark pulse only stands with dark mode
  a_dark_mode: assert property (@(posedge clk) disable iff (rst)
    dark_flag |-> (mode_reg == MODE_DARK))
    else $error("dark pulse without dark mode");

endmodule

`default_nettype wire
